/* rtl/mtg_pkg.sv */
// package with types, constants and the tempering function of the mt19937 generator
`timescale 1ns / 1ps
`default_nettype none

package mtg_pkg;

    localparam logic [31:0] SEED_MULT    = 32'h6c07_8965;
    localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

    localparam logic OP_SEED = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    typedef enum logic [2:0] {
        ST_SEED,
        ST_IDLE,
        ST_PRIME,
        ST_LOAD,
        ST_TWIST,
        ST_DRAW_RD,
        ST_DRAW_OUT
    } mtg_state_t;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

`default_nettype wire

/* rtl/mtg_ram.sv */
// generic ram with one write port and two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module mtg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic      [WIDTH-1:0]         rd_data_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_a <= mem_reg[rd_addr_a];
        rd_data_b <= mem_reg[rd_addr_b];
    end

endmodule

`default_nettype wire

/* rtl/mersenne_twister_generator.sv */
// top level of the mt19937 generator: sequencer, seed unit, twist unit and tempering
//
//  channel | dir | ports                                 | carries
//  s_      | in  | s_valid s_ready s_operation s_seed_value | seed or draw request
//  m_      | out | m_valid m_ready m_random_word           | tempered word per draw
//
// after reset the state is filled as seeded with 0, with s_ready low
// a seed beat is the accept followed by 624 state word writes
// a draw tempers one word; it twists all 624 words first when none are left unread
// the single ram write port sets the pace: one state word per cycle
// the output register lets a new beat in while a word waits for m_ready
`timescale 1ns / 1ps
`default_nettype none

module mersenne_twister_generator
    import mtg_pkg::*;
#(
    parameter int STATE_WORDS  = 624,
    parameter int TWIST_OFFSET = 397
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_operation,
    input  wire logic [31:0] s_seed_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [31:0] m_random_word
);

    localparam int ADDR_W = $clog2(STATE_WORDS);
    localparam int POS_W  = $clog2(STATE_WORDS + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_WORDS - 1);

    function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + 1'b1;
    endfunction

    mtg_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] nxt_reg, nxt_next;
    logic [ADDR_W-1:0] far_reg, far_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [31:0]       prev_reg, prev_next;
    logic [31:0]       cur_reg, cur_next;
    logic [31:0]       out_reg, out_next;
    logic              mvalid_reg, mvalid_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       wr_data;
    logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
    logic [31:0]       rd_data_a, rd_data_b;

    logic              s_beat;
    logic              out_free;
    logic              idx_last;
    logic              pos_empty;
    logic [31:0]       mixed;
    logic [31:0]       seed_word;
    logic [31:0]       twist_y;
    logic [31:0]       twist_word;

    mtg_ram #(
        .WIDTH (32),
        .DEPTH (STATE_WORDS)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    assign s_ready       = (state_reg == ST_IDLE);
    assign s_beat        = s_valid && s_ready;
    assign m_valid       = mvalid_reg;
    assign m_random_word = out_reg;
    assign out_free      = !mvalid_reg || m_ready;
    assign idx_last      = (idx_reg == LAST_ADDR);
    assign pos_empty     = (pos_reg >= POS_W'(STATE_WORDS));

    // seed recurrence
    assign mixed     = prev_reg ^ (prev_reg >> 30);
    assign seed_word = (idx_reg == '0) ? prev_reg : (mixed * SEED_MULT) + 32'(idx_reg);

    // twist of one word
    assign twist_y    = {cur_reg[31], rd_data_a[30:0]};
    assign twist_word = rd_data_b ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : 32'h0);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_SEED: begin
                if (idx_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_operation == OP_SEED) begin
                        state_next = ST_SEED;
                    end else if (pos_empty) begin
                        state_next = ST_PRIME;
                    end else begin
                        state_next = ST_DRAW_RD;
                    end
                end
            end
            ST_PRIME:   state_next = ST_LOAD;
            ST_LOAD:    state_next = ST_TWIST;
            ST_TWIST: begin
                if (idx_last) begin
                    state_next = ST_DRAW_RD;
                end
            end
            ST_DRAW_RD: state_next = ST_DRAW_OUT;
            ST_DRAW_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        idx_next    = idx_reg;
        nxt_next    = nxt_reg;
        far_next    = far_reg;
        pos_next    = pos_reg;
        prev_next   = prev_reg;
        cur_next    = cur_reg;
        out_next    = out_reg;
        mvalid_next = mvalid_reg && !m_ready;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = seed_word;
        rd_addr_a   = '0;
        rd_addr_b   = far_reg;
        case (state_reg)
            ST_SEED: begin
                wr_en     = 1'b1;
                prev_next = seed_word;
                idx_next  = wrap_inc(idx_reg);
            end
            ST_IDLE: begin
                if (s_beat && s_operation == OP_SEED) begin
                    prev_next = s_seed_value;
                    idx_next  = '0;
                    pos_next  = POS_W'(STATE_WORDS);
                end
            end
            ST_PRIME: begin
                idx_next = '0;
                nxt_next = wrap_inc('0);
                far_next = ADDR_W'(TWIST_OFFSET);
            end
            ST_LOAD: begin
                cur_next  = rd_data_a;
                rd_addr_a = nxt_reg;
                rd_addr_b = far_reg;
            end
            ST_TWIST: begin
                wr_en     = 1'b1;
                wr_data   = twist_word;
                cur_next  = rd_data_a;
                idx_next  = wrap_inc(idx_reg);
                nxt_next  = wrap_inc(nxt_reg);
                far_next  = wrap_inc(far_reg);
                rd_addr_a = nxt_next;
                rd_addr_b = far_next;
                if (idx_last) begin
                    pos_next = '0;
                end
            end
            ST_DRAW_RD: begin
                rd_addr_a = pos_reg[ADDR_W-1:0];
            end
            ST_DRAW_OUT: begin
                rd_addr_a = pos_reg[ADDR_W-1:0];
                if (out_free) begin
                    out_next    = temper(rd_data_a);
                    mvalid_next = 1'b1;
                    pos_next    = pos_reg + 1'b1;
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_SEED;
            idx_reg    <= '0;
            prev_reg   <= '0;
            pos_reg    <= POS_W'(STATE_WORDS);
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            prev_reg   <= prev_next;
            pos_reg    <= pos_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        nxt_reg <= nxt_next;
        far_reg <= far_next;
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

/* rtl/mtg_checker.sv */
// port-level checker for the mt19937 generator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module mtg_port_checker
    import mtg_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_operation,
    input wire logic [31:0] s_seed_value,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_random_word
);

    // stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_random_word))
        else $error("result beat dropped or changed while stalled");

    // the block is busy right after every input beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken back to back");

    // a seed beat never raises a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation == OP_SEED |=> !$rose(m_valid))
        else $error("result after seed beat");

    // a new result only appears out of a busy period
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without work");

    // initial seeding keeps the input closed right after reset
    assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !s_ready && !m_valid)
        else $error("ready or valid right after reset");

endmodule

bind mersenne_twister_generator mtg_port_checker u_mtg_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_operation   (s_operation),
    .s_seed_value  (s_seed_value),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_random_word (m_random_word)
);

`default_nettype wire
